@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the radial dead-zone filter checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only while reset is low.
`define RDZ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radial dead-zone filter check failed");

// Implication checked at every edge, reset included.
`define RDZ_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("radial dead-zone filter check failed");

`endif

@@ hw/rtl/rdz_pkg.sv @@
// ----------------------------------------------------------------------------
// Radial dead-zone filter package
// Shared constants, register indexes and pipeline types.
// ----------------------------------------------------------------------------
package rdz_pkg;

  localparam int RDZ_AXIS_BITS = 16;
  localparam int RDZ_DZ_RESET = 8000;
  localparam int RDZ_FS_RESET = 30000;

  localparam logic REG_DEAD_ZONE = 1'b0;
  localparam logic REG_FULL_SCALE = 1'b1;

  typedef struct packed {
    logic valid;
    logic zero;
    logic neg_x;
    logic neg_y;
  } rdz_tag_t;

  function automatic int rdz_latency(input int axis_bits);
    return 2 * axis_bits + 7;
  endfunction

endpackage

@@ hw/rtl/rdz_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per register stage, floor of the square root.
// ----------------------------------------------------------------------------
module rdz_isqrt #(
  parameter int AXIS_BITS = 16
) (
  input  logic                     clk,
  input  logic [2*AXIS_BITS+1:0]   value,
  output logic [AXIS_BITS:0]       root
);
  import rdz_pkg::*;

  localparam int SQW = 2 * AXIS_BITS + 2;
  localparam int LW = AXIS_BITS + 1;

  logic [SQW-1:0] rem_q [1:AXIS_BITS+1];
  logic [LW-1:0] root_q [1:AXIS_BITS+1];

  for (genvar g = 0; g <= AXIS_BITS; g++) begin : g_stage
    localparam int K = AXIS_BITS - g;
    logic [SQW-1:0] rem_in;
    logic [LW-1:0] root_in;
    logic [SQW-1:0] trial;

    if (g == 0) begin : g_first
      assign rem_in = value;
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[g];
      assign root_in = root_q[g];
    end

    assign trial = (SQW'(root_in) << (K + 1)) + (SQW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_q[g+1] <= rem_in - trial;
        root_q[g+1] <= root_in | (LW'(1) << K);
      end else begin
        rem_q[g+1] <= rem_in;
        root_q[g+1] <= root_in;
      end
    end
  end

  assign root = root_q[AXIS_BITS+1];

endmodule

@@ hw/rtl/rdz_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides a product scaled to 1.0 by the scale denominator, one quotient bit
// per register stage.
// ----------------------------------------------------------------------------
module rdz_div #(
  parameter int AXIS_BITS = 16
) (
  input  logic                   clk,
  input  logic [2*AXIS_BITS:0]   dividend,
  input  logic [2*AXIS_BITS:0]   divisor,
  output logic [AXIS_BITS-1:0]   quotient
);
  import rdz_pkg::*;

  localparam int PW = 2 * AXIS_BITS + 1;
  localparam int DW = 3 * AXIS_BITS;

  logic [DW-1:0] rem_q [1:AXIS_BITS];
  logic [PW-1:0] den_q [1:AXIS_BITS];
  logic [AXIS_BITS-1:0] quo_q [1:AXIS_BITS];

  for (genvar j = 0; j < AXIS_BITS; j++) begin : g_stage
    localparam int K = AXIS_BITS - 1 - j;
    logic [DW-1:0] rem_in;
    logic [PW-1:0] den_in;
    logic [AXIS_BITS-1:0] quo_in;
    logic [DW-1:0] sub;

    if (j == 0) begin : g_first
      assign rem_in = DW'(dividend) << (AXIS_BITS - 1);
      assign den_in = divisor;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[j];
      assign den_in = den_q[j];
      assign quo_in = quo_q[j];
    end

    assign sub = DW'(den_in) << K;

    always_ff @(posedge clk) begin
      den_q[j+1] <= den_in;
      if (rem_in >= sub) begin
        rem_q[j+1] <= rem_in - sub;
        quo_q[j+1] <= quo_in | (AXIS_BITS'(1) << K);
      end else begin
        rem_q[j+1] <= rem_in;
        quo_q[j+1] <= quo_in;
      end
    end
  end

  assign quotient = quo_q[AXIS_BITS];

endmodule

@@ hw/rtl/radial_dead_zone_stick_filter_top.sv @@
// ----------------------------------------------------------------------------
// Radial dead-zone stick filter
// Rescales one stick vector so that its magnitude rises from zero at the dead
// zone radius to 1.0 at the full scale radius.
//
// Channel   Direction  Handshake              Payload
// command   in         start, busy            stick_x, stick_y
// result    out        done (one cycle)       out_x, out_y
// config    in         psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// A new sample is taken in every cycle; busy stays low.
// Each sample passes through the input registers, the square root pipeline,
// the scaling registers, the divider pipeline and the output register.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module radial_dead_zone_stick_filter_top #(
  parameter int AXIS_BITS = rdz_pkg::RDZ_AXIS_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [AXIS_BITS:0]   stick_x,
  input  logic signed [AXIS_BITS:0]   stick_y,
  output logic                        done,
  output logic signed [AXIS_BITS:0]   out_x,
  output logic signed [AXIS_BITS:0]   out_y,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rdz_pkg::*;

  localparam int A = AXIS_BITS;
  localparam int W = A + 1;
  localparam int SQW = 2 * A + 2;
  localparam int PW = 2 * A + 1;

  logic [A-1:0] dead_zone;
  logic [A-1:0] full_scale;

  assign pready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= A'(RDZ_DZ_RESET);
      full_scale <= A'(RDZ_FS_RESET);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DEAD_ZONE: dead_zone <= pwdata[A-1:0];
        REG_FULL_SCALE: full_scale <= pwdata[A-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEAD_ZONE: prdata = 32'(dead_zone);
      REG_FULL_SCALE: prdata = 32'(full_scale);
      default: prdata = '0;
    endcase
  end

  rdz_tag_t s1_tag, s2_tag, s3_tag, m1_tag, m2_tag;
  logic [W-1:0] s1_mx, s1_my, s2_mx, s2_my;
  logic [SQW-1:0] s2_px, s2_py, s3_sq;
  logic [2*A-1:0] s2_dz2;
  logic [SQW-1:0] sq_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
    end else begin
      s1_tag <= '{valid: start, zero: 1'b0, neg_x: stick_x[A], neg_y: stick_y[A]};
      s2_tag <= s1_tag;
      s3_tag <= '{valid: s2_tag.valid, zero: sq_sum < SQW'(s2_dz2),
                  neg_x: s2_tag.neg_x, neg_y: s2_tag.neg_y};
    end
  end

  assign sq_sum = s2_px + s2_py;

  always_ff @(posedge clk) begin
    s1_mx <= stick_x[A] ? W'(~stick_x + 1'b1) : W'(stick_x);
    s1_my <= stick_y[A] ? W'(~stick_y + 1'b1) : W'(stick_y);
    s2_px <= SQW'(s1_mx) * SQW'(s1_mx);
    s2_py <= SQW'(s1_my) * SQW'(s1_my);
    s2_dz2 <= (2*A)'(dead_zone) * (2*A)'(dead_zone);
    s2_mx <= s1_mx;
    s2_my <= s1_my;
    s3_sq <= sq_sum;
  end

  logic [A:0] len;

  rdz_isqrt #(.AXIS_BITS(A)) u_isqrt (
    .clk   (clk),
    .value (s3_sq),
    .root  (len)
  );

  rdz_tag_t sq_tag [1:A+1];
  logic [W-1:0] sq_mx [1:A+1];
  logic [W-1:0] sq_my [1:A+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= A + 1; i++) begin
        sq_tag[i] <= '0;
      end
    end else begin
      sq_tag[1] <= s3_tag;
      for (int i = 2; i <= A + 1; i++) begin
        sq_tag[i] <= sq_tag[i-1];
      end
    end
  end

  logic [W-1:0] s3_mx, s3_my;
  always_ff @(posedge clk) begin
    s3_mx <= s2_mx;
    s3_my <= s2_my;
  end

  always_ff @(posedge clk) begin
    sq_mx[1] <= s3_mx;
    sq_my[1] <= s3_my;
    for (int i = 2; i <= A + 1; i++) begin
      sq_mx[i] <= sq_mx[i-1];
      sq_my[i] <= sq_my[i-1];
    end
  end

  logic [A:0] m1_len;
  logic [A-1:0] m1_num, m1_den;
  logic [W-1:0] m1_mx, m1_my;
  logic unity;
  logic [A-1:0] span;
  logic [A:0] over;

  assign unity = full_scale <= dead_zone;
  assign span = full_scale - dead_zone;
  assign over = len - W'(dead_zone);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_tag <= '0;
      m2_tag <= '0;
    end else begin
      m1_tag <= '{valid: sq_tag[A+1].valid, zero: sq_tag[A+1].zero || (len == '0),
                  neg_x: sq_tag[A+1].neg_x, neg_y: sq_tag[A+1].neg_y};
      m2_tag <= m1_tag;
    end
  end

  always_ff @(posedge clk) begin
    m1_len <= len;
    m1_mx <= sq_mx[A+1];
    m1_my <= sq_my[A+1];
    if (unity) begin
      m1_num <= A'(1);
      m1_den <= A'(1);
    end else begin
      m1_num <= (over > W'(span)) ? span : over[A-1:0];
      m1_den <= span;
    end
  end

  logic [PW-1:0] m2_nx, m2_ny, m2_d;
  always_ff @(posedge clk) begin
    m2_nx <= PW'(m1_mx) * PW'(m1_num);
    m2_ny <= PW'(m1_my) * PW'(m1_num);
    m2_d <= PW'(m1_den) * PW'(m1_len);
  end

  logic [A-1:0] qx, qy;

  rdz_div #(.AXIS_BITS(A)) u_div_x (
    .clk      (clk),
    .dividend (m2_nx),
    .divisor  (m2_d),
    .quotient (qx)
  );

  rdz_div #(.AXIS_BITS(A)) u_div_y (
    .clk      (clk),
    .dividend (m2_ny),
    .divisor  (m2_d),
    .quotient (qy)
  );

  rdz_tag_t dv_tag [1:A];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= A; i++) begin
        dv_tag[i] <= '0;
      end
    end else begin
      dv_tag[1] <= m2_tag;
      for (int i = 2; i <= A; i++) begin
        dv_tag[i] <= dv_tag[i-1];
      end
    end
  end

  logic [W-1:0] ux, uy;
  assign ux = {1'b0, qx};
  assign uy = {1'b0, qy};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_tag[A].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_tag[A].zero) begin
      out_x <= '0;
      out_y <= '0;
    end else begin
      out_x <= dv_tag[A].neg_x ? $signed(~ux + 1'b1) : $signed(ux);
      out_y <= dv_tag[A].neg_y ? $signed(~uy + 1'b1) : $signed(uy);
    end
  end

endmodule

@@ hw/rtl/rdz_checker.sv @@
// ----------------------------------------------------------------------------
// Radial dead-zone filter checker
// Port-level checks on result timing, reset, output range and output sign.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdz_checker #(
  parameter int AXIS_BITS = rdz_pkg::RDZ_AXIS_BITS
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic signed [AXIS_BITS:0]   stick_y,
  input logic                        done,
  input logic signed [AXIS_BITS:0]   out_x,
  input logic signed [AXIS_BITS:0]   out_y
);
  import rdz_pkg::*;

  localparam int LAT = rdz_latency(AXIS_BITS);
  localparam logic [AXIS_BITS-1:0] ONE_Q = AXIS_BITS'(1) << (AXIS_BITS - 1);

  `RDZ_ASSERT_IMP(a_done_follows_start, clk, rst, done, $past(start && !busy, LAT))
  `RDZ_ASSERT_ALWAYS(a_reset_clears_done, clk, $past(rst), !done)
  `RDZ_ASSERT_IMP(a_x_in_range, clk, rst, done && !out_x[AXIS_BITS], out_x[AXIS_BITS-1:0] <= ONE_Q)
  `RDZ_ASSERT_IMP(a_y_sign, clk, rst, done && (out_y != '0), out_y[AXIS_BITS] == $past(stick_y[AXIS_BITS], LAT))

endmodule

bind radial_dead_zone_stick_filter_top rdz_checker #(.AXIS_BITS(AXIS_BITS)) u_rdz_checker (.*);
